/* hw/rtl/nnis_pkg.sv */
package nnis_pkg;

   // Store geometry
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_DST_DIM    = 4096;

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SX_W        = $clog2(MAX_SRC_WIDTH);
   localparam int SY_W        = $clog2(MAX_SRC_HEIGHT);

   // Field widths
   localparam int COORD_W = 12;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int SRC_W   = 9;
   localparam int DST_W   = 12;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   // Divider: one quotient bit per stage after the numerator stage
   localparam int Q_W        = SRC_W;
   localparam int NUM_W      = COORD_W + SRC_W + 2;
   localparam int DIV_STAGES = Q_W + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic [SRC_W-1:0] SRC_SIZE_RESET = 9'd256;
   localparam logic [DST_W-1:0] DST_SIZE_RESET = 12'd256;

   // Function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Per-word side information travelling alongside the divider
   typedef struct packed {
      logic             func;
      logic             err;
      logic             wr_ok;
      logic [SX_W-1:0]  wcol;
      logic [SY_W-1:0]  wrow;
      logic [PIX_W-1:0] rgb;
   } item_meta_type;

   // Single-port access to the pixel store
   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } store_req_type;

endpackage

/* hw/rtl/nnis_divider.sv */
module nnis_divider
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [COORD_W-1:0]    coord,
   input  logic [SRC_W-1:0]      src_size,
   input  logic [DST_W-1:0]      dst_size,
   output logic [Q_W-1:0]        quot
);

   logic [COORD_W+SRC_W-1:0] prod;
   logic [NUM_W-1:0]         num_in;
   logic [NUM_W-1:0]         rem_ff [DIV_STAGES];
   logic [Q_W-1:0]           quo_ff [DIV_STAGES];

   // Form numerator 2*d*S + D
   assign prod   = (COORD_W+SRC_W)'(coord) * (COORD_W+SRC_W)'(src_size);
   assign num_in = NUM_W'({prod, 1'b0}) + NUM_W'(dst_size);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0] <= num_in;
         quo_ff[0] <= '0;
      end
   end

   // Resolve one quotient bit per stage against 2*D, most significant first
   for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
      localparam int K = Q_W - j;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      assign dsh    = NUM_W'({dst_size, 1'b0}) << K;
      assign ge     = rem_ff[j-1] >= dsh;
      assign rem_in = ge ? rem_ff[j-1] - dsh : rem_ff[j-1];
      assign quo_in = ge ? (quo_ff[j-1] | (Q_W'(1) << K)) : quo_ff[j-1];

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quot = quo_ff[DIV_STAGES-1];

endmodule

/* hw/rtl/nnis_pixel_store.sv */
module nnis_pixel_store
   import nnis_pkg::*;
(
   input  logic               clock,
   input  store_req_type      req,
   output logic [PIX_W-1:0]   rd_data
);

   logic [PIX_W-1:0] mem_array [STORE_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (req.en && req.we) begin
         mem_array[req.addr] <= req.wdata;
      end
   end

   // Registered read; hold the last word when not reading
   always_ff @(posedge clock) begin
      if (req.en && !req.we) begin
         rd_data_ff <= mem_array[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nearest_neighbor_image_scaler_unit.sv */
// A read word passes through ten pipeline stages, then the result register.
// Throughput: one word per cycle unless every stage is full behind a stalled
// result word; the coordinate dividers resolve one quotient bit per pipeline
// stage and the pixel store takes one access per cycle.
// Reset clears the pipeline and sets all four sizes to 256. The pixel store is
// not cleared; entries hold whatever was last written.
module nearest_neighbor_image_scaler_unit
   import nnis_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [CHAN_W-1:0]    req_red_in,
   input  logic [CHAN_W-1:0]    req_green_in,
   input  logic [CHAN_W-1:0]    req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_red_out,
   output logic [CHAN_W-1:0]    rsp_green_out,
   output logic [CHAN_W-1:0]    rsp_blue_out,
   output logic                 rsp_coord_error,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int L = DIV_STAGES - 1;

   logic [SRC_W-1:0]      src_width_ff, src_height_ff;
   logic [DST_W-1:0]      dst_width_ff, dst_height_ff;
   logic [SRC_W-1:0]      sw_eff, sh_eff;
   logic [DST_W-1:0]      dw_eff, dh_eff;

   logic [DIV_STAGES-1:0] stage_valid_ff;
   item_meta_type         meta_ff [DIV_STAGES];
   item_meta_type         meta_in;
   logic [DIV_STAGES-1:0] can_recv;
   logic                  out_free;
   logic                  leave_last;

   logic [Q_W-1:0]        qx, qy;
   logic [Q_W-1:0]        qx_cl, qy_cl;
   logic [SX_W-1:0]       col_sel;
   logic [SY_W-1:0]       row_sel;
   logic                  rd_go, wr_go;
   store_req_type         store_req;
   logic [PIX_W-1:0]      rd_data;

   logic                  rsp_valid_ff, rsp_err_ff;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_SIZE_RESET;
         src_height_ff <= SRC_SIZE_RESET;
         dst_width_ff  <= DST_SIZE_RESET;
         dst_height_ff <= DST_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SRC_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SRC_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[DST_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[DST_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes: zero source acts as one, clamp to the store and max dims
   always_comb begin
      sw_eff = src_width_ff;
      if (src_width_ff == '0) sw_eff = SRC_W'(1);
      else if (32'(src_width_ff) > MAX_SRC_WIDTH) sw_eff = SRC_W'(MAX_SRC_WIDTH);
      sh_eff = src_height_ff;
      if (src_height_ff == '0) sh_eff = SRC_W'(1);
      else if (32'(src_height_ff) > MAX_SRC_HEIGHT) sh_eff = SRC_W'(MAX_SRC_HEIGHT);
      dw_eff = dst_width_ff;
      if (32'(dst_width_ff) > MAX_DST_DIM) dw_eff = DST_W'(MAX_DST_DIM);
      dh_eff = dst_height_ff;
      if (32'(dst_height_ff) > MAX_DST_DIM) dh_eff = DST_W'(MAX_DST_DIM);
   end

   // Classify the incoming word
   always_comb begin
      meta_in.func  = req_func;
      meta_in.err   = (req_col >= dw_eff) || (req_row >= dh_eff);
      meta_in.wr_ok = (req_col < COORD_W'(sw_eff)) && (req_row < COORD_W'(sh_eff));
      meta_in.wcol  = SX_W'(req_col);
      meta_in.wrow  = SY_W'(req_row);
      meta_in.rgb   = {req_red_in, req_green_in, req_blue_in};
   end

   // Stage advance: a stage takes new data if it or any later stage has a gap
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign leave_last = out_free || (meta_ff[L].func == FUNC_WRITE);

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         can_recv[i] = leave_last ||
            ((stage_valid_ff | ~({DIV_STAGES{1'b1}} << i)) != {DIV_STAGES{1'b1}});
      end
   end

   assign req_stall = !can_recv[0];

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (can_recv[0]) stage_valid_ff[0] <= req_valid;
         for (int i = 1; i < DIV_STAGES; i++) begin
            if (can_recv[i]) stage_valid_ff[i] <= stage_valid_ff[i-1];
         end
      end
   end

   // Side information shift line
   always_ff @(posedge clock) begin
      if (can_recv[0]) meta_ff[0] <= meta_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
         if (can_recv[i]) meta_ff[i] <= meta_ff[i-1];
      end
   end

   // Column and row dividers
   nnis_divider u_div_x (
      .clock    (clock),
      .stage_en (can_recv),
      .coord    (req_col),
      .src_size (sw_eff),
      .dst_size (dw_eff),
      .quot     (qx)
   );

   nnis_divider u_div_y (
      .clock    (clock),
      .stage_en (can_recv),
      .coord    (req_row),
      .src_size (sh_eff),
      .dst_size (dh_eff),
      .quot     (qy)
   );

   // Clamp to the last source pixel and form the store access
   always_comb begin
      qx_cl = (qx >= sw_eff) ? sw_eff - SRC_W'(1) : qx;
      qy_cl = (qy >= sh_eff) ? sh_eff - SRC_W'(1) : qy;

      rd_go = stage_valid_ff[L] && (meta_ff[L].func == FUNC_READ) &&
              !meta_ff[L].err && out_free;
      wr_go = stage_valid_ff[L] && (meta_ff[L].func == FUNC_WRITE) && meta_ff[L].wr_ok;

      col_sel = wr_go ? meta_ff[L].wcol : SX_W'(qx_cl);
      row_sel = wr_go ? meta_ff[L].wrow : SY_W'(qy_cl);

      store_req.en    = rd_go || wr_go;
      store_req.we    = wr_go;
      store_req.addr  = ADDR_W'(row_sel) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(col_sel);
      store_req.wdata = meta_ff[L].rgb;
   end

   nnis_pixel_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (rd_data)
   );

   // Result word register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff[L] && (meta_ff[L].func == FUNC_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) rsp_err_ff <= meta_ff[L].err;
   end

   // Drop colours for coordinates outside the destination
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coord_error = rsp_err_ff;
   assign rsp_red_out     = rsp_err_ff ? '0 : rd_data[3*CHAN_W-1:2*CHAN_W];
   assign rsp_green_out   = rsp_err_ff ? '0 : rd_data[2*CHAN_W-1:CHAN_W];
   assign rsp_blue_out    = rsp_err_ff ? '0 : rd_data[CHAN_W-1:0];

   // Input stalls only when every stage is full behind a blocked result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&stage_valid_ff) && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // One store access per cycle
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(rd_go && wr_go))
      else $error("read and write to pixel store in the same cycle");

   // An accepted word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid_ff[0])
      else $error("accepted word lost at pipeline entry");

   // A store read yields an in-range result next cycle
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      rd_go |=> (rsp_valid_ff && !rsp_err_ff))
      else $error("store read without a matching result word");

endmodule
